>>> sv/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned ROUND_KEY_WORDS = 44;
  localparam int unsigned KEY_COLS        = 4;
  localparam int unsigned KEY_ROWS        = ROUND_KEY_WORDS / KEY_COLS;
  localparam int unsigned ROW_W           = $clog2(KEY_ROWS);
  localparam int unsigned IDX_W           = 6;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ENCRYPT = 1'b1;

  typedef struct packed {
    logic             load_block;
    logic             key_write;
    logic             init_add;
    logic             do_round;
    logic             final_round;
    logic [ROW_W-1:0] rd_row;
  } aes_cmd_t;

  typedef struct packed {
    logic out_free;
  } aes_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

>>> sv/aes_ctrl.sv
`timescale 1ns / 1ps
module aes_ctrl
  import aes_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     action_i,
  input  aes_sts_t sts_i,
  output logic     in_ready_o,
  output aes_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [ROW_W-1:0] LAST_ROUND = ROW_W'(KEY_ROWS - 1);

  logic             state_q, state_d;
  logic [ROW_W-1:0] rnd_q, rnd_d;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        rnd_d      = '0;
        if (in_valid_i) begin
          if (action_i == ACT_ENCRYPT) begin
            cmd_o.load_block = 1'b1;
            state_d          = S_RUN;
          end else begin
            cmd_o.key_write = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (rnd_q == '0) begin
          cmd_o.init_add = 1'b1;
          rnd_d          = rnd_q + ROW_W'(1);
        end else if (rnd_q == LAST_ROUND) begin
          // hold the last round until the output word is free
          if (sts_i.out_free) begin
            cmd_o.final_round = 1'b1;
            state_d           = S_IDLE;
            rnd_d             = '0;
          end
        end else begin
          cmd_o.do_round = 1'b1;
          rnd_d          = rnd_q + ROW_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
        rnd_d   = '0;
      end
    endcase
    cmd_o.rd_row = rnd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

>>> sv/aes_dp.sv
`timescale 1ns / 1ps
module aes_dp
  import aes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aes_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] key_index_i,
  input  logic [31:0]      key_word_i,
  input  logic [63:0]      block_hi_i,
  input  logic [63:0]      block_lo_i,
  input  logic             out_ready_i,
  output aes_sts_t         sts_o,
  output logic             out_valid_o,
  output logic [63:0]      cipher_hi_o,
  output logic [63:0]      cipher_lo_o
);

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int           src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) % 4) + r;
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = s[127 - 8 * (4 * c + r) -: 8];
      end
      x = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = a[r] ^ x ^ xtime(a[r] ^ a[(r + 1) % 4]);
      end
    end
    mix_columns = t;
  endfunction

  logic [31:0]  rk_q [KEY_COLS];
  logic [127:0] kv;
  logic [127:0] st_q, st_d;
  logic [127:0] ss;
  logic [127:0] cipher_q;
  logic         out_valid_q, out_valid_d;
  logic         key_we;
  logic [ROW_W-1:0] wr_row;
  logic [1:0]   wr_col;

  assign key_we = cmd_i.key_write && (key_index_i < IDX_W'(ROUND_KEY_WORDS));
  assign wr_row = key_index_i[2 +: ROW_W];
  assign wr_col = key_index_i[1:0];

  for (genvar b = 0; b < KEY_COLS; b++) begin : g_bank
    logic [31:0] mem_q [KEY_ROWS];

    always_ff @(posedge clk_i) begin
      if (key_we && (wr_col == 2'(b))) begin
        mem_q[wr_row] <= key_word_i;
      end
      rk_q[b] <= mem_q[cmd_i.rd_row];
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        kv[127 - 8 * (4 * c + r) -: 8] = rk_q[c][8 * r +: 8];
      end
    end
  end

  assign ss = sub_shift(st_q);

  always_comb begin
    st_d = st_q;
    if (cmd_i.load_block) begin
      st_d = {block_hi_i, block_lo_i};
    end else if (cmd_i.init_add) begin
      st_d = st_q ^ kv;
    end else if (cmd_i.do_round) begin
      st_d = mix_columns(ss) ^ kv;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (cmd_i.final_round) begin
      cipher_q <= ss ^ kv;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.final_round) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign cipher_hi_o    = cipher_q[127:64];
  assign cipher_lo_o    = cipher_q[63:0];

endmodule

>>> sv/aes128_block_encrypt_top.sv
// An encrypt word is worked by the single round unit, which iterates the initial
// key add and ten rounds behind a registered round-key read; the final round
// waits until the output word is free, and no new word is taken until it ends.
// A load word writes one round-key word (index below 44) and gives no result.
// Reset clears the controller and the output valid; round keys are not reset.
`timescale 1ns / 1ps
module aes128_block_encrypt_top
  import aes_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [IDX_W-1:0] key_index_i,
  input  logic [31:0]      key_word_i,
  input  logic [63:0]      block_hi_i,
  input  logic [63:0]      block_lo_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      cipher_hi_o,
  output logic [63:0]      cipher_lo_o
);

  aes_cmd_t cmd;
  aes_sts_t sts;

  aes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  aes_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .key_index_i (key_index_i),
    .key_word_i  (key_word_i),
    .block_hi_i  (block_hi_i),
    .block_lo_i  (block_lo_i),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .cipher_hi_o (cipher_hi_o),
    .cipher_lo_o (cipher_lo_o)
  );

`ifndef SYNTHESIS
  a_idle_no_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.init_add || cmd.do_round || cmd.final_round))
    else $error("round command while accepting input");

  a_rose_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.final_round))
    else $error("output valid without final round");

  a_final_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.final_round |=> (in_ready_o && out_valid_o))
    else $error("final round did not deliver and return idle");
`endif

endmodule
